FILE: src/sdm_pkg.sv
// Shared types, codes and constants for the sparse DP mask builder.
`default_nettype none
package sdm_pkg;

    localparam int LANES_DEF         = 16;
    localparam int MAX_MODEL_DEF     = 2048;
    localparam int MAX_SEQUENCE_DEF  = 4096;
    localparam int CELL_CAPACITY_DEF = 65536;

    localparam int CMD_W      = 3;
    localparam int ROW_W      = 13;
    localparam int STRIPE_W   = 7;
    localparam int LANE_W     = 4;
    localparam int RIDX_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int CELLK_W    = 12;
    localparam int RCOUNT_W   = 12;
    localparam int ROFF_W     = 17;
    localparam int SEG_W      = 14;
    localparam int SEGTOT_W   = 12;
    localparam int RMARK_W    = 13;
    localparam int CTOT_W     = 17;
    localparam int MLEN_W     = 12;
    localparam int SLEN_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_LENGTH = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN       = 3'd0,
        CMD_START_ROW   = 3'd1,
        CMD_ADD_CELL    = 3'd2,
        CMD_FINISH_ROW  = 3'd3,
        CMD_FINISH_MASK = 3'd4,
        CMD_READ_CELL   = 3'd5,
        CMD_READ_ROW    = 3'd6,
        CMD_READ_SEG    = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_ROW      = 3'd1,
        STAT_CELL     = 3'd2,
        STAT_OVERFLOW = 3'd3,
        STAT_INDEX    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_FR_LANE,
        S_FR_COPY,
        S_FR_FLUSH,
        S_REV_RD,
        S_REV_WA,
        S_REV_WB,
        S_SC_INIT,
        S_SC_LOAD,
        S_SC_RD,
        S_SC_PROC,
        S_SC_END,
        S_RD_WAIT
    } state_t;

    typedef enum logic [1:0] {
        RK_CELL,
        RK_ROW,
        RK_SEG
    } rd_kind_t;

endpackage
`default_nettype wire

FILE: src/sdm_req_if.sv
// Command channel: valid/ready transfer of one input item.
`default_nettype none
interface sdm_req_if;
    logic                          valid;
    logic                          ready;
    logic [sdm_pkg::CMD_W-1:0]     cmd;
    logic [sdm_pkg::ROW_W-1:0]     row;
    logic [sdm_pkg::STRIPE_W-1:0]  stripe_index;
    logic [sdm_pkg::LANE_W-1:0]    lane;
    logic [sdm_pkg::RIDX_W-1:0]    read_index;

    modport source (output valid, cmd, row, stripe_index, lane, read_index, input ready);
    modport sink   (input valid, cmd, row, stripe_index, lane, read_index, output ready);
endinterface
`default_nettype wire

FILE: src/sdm_rsp_if.sv
// Result channel: valid/ready transfer of one result item.
`default_nettype none
interface sdm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sdm_pkg::STATUS_W-1:0]        status;
    logic [sdm_pkg::CELLK_W-1:0]         cell_k;
    logic [sdm_pkg::RCOUNT_W-1:0]        row_count;
    logic [sdm_pkg::ROFF_W-1:0]          row_offset;
    logic signed [sdm_pkg::SEG_W-1:0]    segment_start;
    logic signed [sdm_pkg::SEG_W-1:0]    segment_end;
    logic [sdm_pkg::SEGTOT_W-1:0]        segment_total;
    logic [sdm_pkg::RMARK_W-1:0]         rows_marked;
    logic [sdm_pkg::CTOT_W-1:0]          cells_total;

    modport source (output valid, status, cell_k, row_count, row_offset, segment_start,
                    segment_end, segment_total, rows_marked, cells_total, input ready);
    modport sink   (input valid, status, cell_k, row_count, row_offset, segment_start,
                    segment_end, segment_total, rows_marked, cells_total, output ready);
endinterface
`default_nettype wire

FILE: src/sdm_cell_store.sv
// Cell store memory: one write port, two registered read ports.
`default_nettype none
module sdm_cell_store #(
    parameter int CELL_CAPACITY = sdm_pkg::CELL_CAPACITY_DEF,
    parameter int DW            = 12
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(CELL_CAPACITY)-1:0] waddr,
    input  wire logic [DW-1:0]                    wdata,
    input  wire logic [$clog2(CELL_CAPACITY)-1:0] raddr_a,
    input  wire logic [$clog2(CELL_CAPACITY)-1:0] raddr_b,
    output logic      [DW-1:0]                    rdata_a,
    output logic      [DW-1:0]                    rdata_b
);
    logic [DW-1:0] mem [CELL_CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

FILE: src/sparse_dp_mask_builder.sv
// Top level of the sparse DP mask builder: sequencer, small stores and result register.
// One command is taken at a time; the next is taken once its result has been
// transferred or is being transferred. Start row and rejected commands are answered
// from the idle state; add cell and the reads pass through S_ADD or S_RD_WAIT. Finish
// row visits lanes LANES-2 down to 0 and copies their cells one at a time through read
// port A of the cell store. Finish mask swaps cell pairs to reverse the store (read,
// write A, write B), then scans the row counts row by row to build offsets and segments.
// Begin, and likewise the pass after reset, clears the row-count memory one entry a
// cycle; no command is taken while it clears; configuration writes are taken at any time.
`default_nettype none
module sparse_dp_mask_builder #(
    parameter int LANES         = sdm_pkg::LANES_DEF,
    parameter int MAX_MODEL     = sdm_pkg::MAX_MODEL_DEF,
    parameter int MAX_SEQUENCE  = sdm_pkg::MAX_SEQUENCE_DEF,
    parameter int CELL_CAPACITY = sdm_pkg::CELL_CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [sdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sdm_pkg::CFG_DATA_W-1:0]   cfg_data,
    sdm_req_if.sink                               req,
    sdm_rsp_if.source                             rsp
);
    import sdm_pkg::*;

    localparam int LIW       = $clog2(LANES);
    localparam int MW        = $clog2(MAX_MODEL + 1);
    localparam int KW        = $clog2(MAX_MODEL + LANES + 1);
    localparam int CAW       = $clog2(CELL_CAPACITY + 1);
    localparam int CIW       = $clog2(CELL_CAPACITY);
    localparam int PW        = ((CAW > KW) ? CAW : KW) + 2;
    localparam int RW        = $clog2(MAX_SEQUENCE + 3);
    localparam int RCW       = $clog2(MAX_SEQUENCE + 1);
    localparam int SEG_DEPTH = MAX_SEQUENCE / 2 + 3;
    localparam int SIW       = $clog2(SEG_DEPTH);
    localparam int SGW       = RW + 1;

    // configuration
    logic [MLEN_W-1:0] model_length_reg;
    logic [SLEN_W-1:0] sequence_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_length_reg    <= MLEN_W'(1);
            sequence_length_reg <= SLEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODEL_LENGTH:    model_length_reg    <= cfg_data[MLEN_W-1:0];
                CFG_SEQUENCE_LENGTH: sequence_length_reg <= cfg_data[SLEN_W-1:0];
                default:             model_length_reg    <= model_length_reg;
            endcase
        end
    end

    // control and datapath registers
    state_t              state_reg, state_next;
    logic                begin_cmd_reg, begin_cmd_next;
    logic [MW-1:0]       mask_m_reg, mask_m_next;
    logic [RW-1:0]       mask_l_reg, mask_l_next;
    logic [MW-1:0]       mask_q_reg, mask_q_next;
    logic [KW-1:0]       q_acc_reg, q_acc_next;
    logic [RCW-1:0]      clr_addr_reg, clr_addr_next;
    logic [RW-1:0]       current_row_reg, current_row_next;
    logic [CAW-1:0]      stored_reg, stored_next;
    logic [SIW-1:0]      segs_reg, segs_next;
    logic [RW-1:0]       nonempty_reg, nonempty_next;
    logic [LANES-1:0]    lane_open_reg, lane_open_next;
    logic [KW-1:0]       lane_last_reg [LANES];
    logic [KW-1:0]       lane_last_next [LANES];
    logic [MW-1:0]       slot_fill_reg [LANES];
    logic [MW-1:0]       slot_fill_next [LANES];
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       off_reg, off_next;
    logic [LIW-1:0]      lane_reg, lane_next;
    logic [LIW-1:0]      fr_lane_reg, fr_lane_next;
    logic [PW-1:0]       src_reg, src_next;
    logic [PW-1:0]       dst_reg, dst_next;
    logic [MW-1:0]       n_reg, n_next;
    logic [MW-1:0]       j_reg, j_next;
    logic                pend_v_reg, pend_v_next;
    logic [CIW-1:0]      pend_addr_reg, pend_addr_next;
    logic [CAW-1:0]      a_reg, a_next;
    logic [CAW-1:0]      b_reg, b_next;
    logic [MW-1:0]       hold_reg, hold_next;
    logic [RW-1:0]       i_reg, i_next;
    logic [MW-1:0]       prev_reg, prev_next;
    logic [MW-1:0]       cur_reg, cur_next;
    logic [CAW-1:0]      pos_reg, pos_next;
    logic [SIW-1:0]      s_reg, s_next;
    logic [RW-1:0]       start_hold_reg, start_hold_next;
    rd_kind_t            rd_kind_reg, rd_kind_next;
    logic                row_zero_reg, row_zero_next;

    // result register
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [CELLK_W-1:0]  rsp_cell_k_reg;
    logic [RCOUNT_W-1:0] rsp_row_count_reg;
    logic [ROFF_W-1:0]   rsp_row_offset_reg;
    logic [SEG_W-1:0]    rsp_seg_start_reg;
    logic [SEG_W-1:0]    rsp_seg_end_reg;
    logic [SEGTOT_W-1:0] rsp_seg_total_reg;
    logic [RMARK_W-1:0]  rsp_rows_marked_reg;
    logic [CTOT_W-1:0]   rsp_cells_total_reg;

    logic                done;
    status_t             res_status;
    logic [CELLK_W-1:0]  res_cell_k;
    logic [RCOUNT_W-1:0] res_row_count;
    logic [ROFF_W-1:0]   res_row_offset;
    logic [SEG_W-1:0]    res_seg_start;
    logic [SEG_W-1:0]    res_seg_end;

    // memories and their ports
    logic [MW-1:0]       rc_mem [MAX_SEQUENCE + 1];
    logic [CAW-1:0]      off_mem [MAX_SEQUENCE + 1];
    logic [2*SGW-1:0]    seg_mem [SEG_DEPTH];

    logic                cell_we;
    logic [CIW-1:0]      cell_waddr, cell_raddr_a, cell_raddr_b;
    logic [MW-1:0]       cell_wdata, cell_rdata_a, cell_rdata_b;
    logic                rc_we;
    logic [RCW-1:0]      rc_waddr, rc_raddr;
    logic [MW-1:0]       rc_wdata, rc_rdata;
    logic                off_we;
    logic [RCW-1:0]      off_waddr, off_raddr;
    logic [CAW-1:0]      off_wdata, off_rdata;
    logic                seg_we;
    logic [SIW-1:0]      seg_waddr, seg_raddr;
    logic [2*SGW-1:0]    seg_wdata, seg_rdata;

    sdm_cell_store #(
        .CELL_CAPACITY (CELL_CAPACITY),
        .DW            (MW)
    ) u_cell_store (
        .clk     (clk),
        .we      (cell_we),
        .waddr   (cell_waddr),
        .wdata   (cell_wdata),
        .raddr_a (cell_raddr_a),
        .raddr_b (cell_raddr_b),
        .rdata_a (cell_rdata_a),
        .rdata_b (cell_rdata_b)
    );

    always_ff @(posedge clk)
    begin
        if (rc_we)
        begin
            rc_mem[rc_waddr] <= rc_wdata;
        end
        rc_rdata <= rc_mem[rc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            off_mem[off_waddr] <= off_wdata;
        end
        off_rdata <= off_mem[off_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        seg_rdata <= seg_mem[seg_raddr];
    end

    // conditions
    logic           accept;
    logic [MW-1:0]  mm_clamp;
    logic [RW-1:0]  ml_clamp;
    logic           bad_start, bad_add, bad_fin_row, bad_fin_mask;
    logic           bad_rd_cell, bad_rd_row, bad_rd_seg;
    logic           add_bad_k, add_ovf;
    logic [PW-1:0]  add_pos;
    logic           clr_done;
    logic [MW-1:0]  fr_fill;
    logic           fr_last_j;
    logic           rev_more;
    logic           sc_last;
    logic [MW-1:0]  sc_nxt;
    logic [SGW-1:0] sc_start;

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign mm_clamp = (32'(model_length_reg) > MAX_MODEL) ? MW'(MAX_MODEL)
                                                          : MW'(model_length_reg);
    assign ml_clamp = (32'(sequence_length_reg) > MAX_SEQUENCE) ? RW'(MAX_SEQUENCE)
                                                                : RW'(sequence_length_reg);

    assign bad_start    = (req.row == '0) || (32'(req.row) > 32'(mask_l_reg))
                          || (32'(req.row) >= 32'(current_row_reg));
    assign bad_add      = (32'(req.stripe_index) >= 32'(mask_q_reg))
                          || (32'(req.lane) >= LANES)
                          || !lane_open_reg[LIW'(req.lane)];
    assign bad_fin_row  = !lane_open_reg[0] || (current_row_reg == '0)
                          || (current_row_reg > mask_l_reg);
    assign bad_fin_mask = (current_row_reg == '0);
    assign bad_rd_cell  = 32'(req.read_index) >= 32'(stored_reg);
    assign bad_rd_row   = 32'(req.row) > 32'(mask_l_reg);
    assign bad_rd_seg   = (32'(req.read_index) > 32'(segs_reg) + 32'd1)
                          || (32'(req.read_index) >= SEG_DEPTH);

    assign add_bad_k = k_reg >= lane_last_reg[lane_reg];
    assign add_pos   = PW'(stored_reg) + PW'(off_reg) + PW'(slot_fill_reg[lane_reg]);
    assign add_ovf   = add_pos >= PW'(CELL_CAPACITY);

    assign clr_done  = (clr_addr_reg == RCW'(MAX_SEQUENCE)) && (q_acc_reg >= KW'(mask_m_reg));
    assign fr_fill   = slot_fill_reg[fr_lane_reg];
    assign fr_last_j = (j_reg == fr_fill - MW'(1));
    assign rev_more  = a_reg < b_reg;
    assign sc_last   = (i_reg == mask_l_reg);
    assign sc_nxt    = sc_last ? '0 : rc_rdata;
    assign sc_start  = (prev_reg == '0) ? SGW'(i_reg) : SGW'(start_hold_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_done) state_next = S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_BEGIN:       state_next = S_CLEAR;
                        CMD_START_ROW:   state_next = S_IDLE;
                        CMD_ADD_CELL:    state_next = bad_add ? S_IDLE : S_ADD;
                        CMD_FINISH_ROW:  state_next = bad_fin_row ? S_IDLE : S_FR_LANE;
                        CMD_FINISH_MASK: state_next = bad_fin_mask ? S_IDLE : S_REV_RD;
                        CMD_READ_CELL:   state_next = bad_rd_cell ? S_IDLE : S_RD_WAIT;
                        CMD_READ_ROW:    state_next = bad_rd_row ? S_IDLE : S_RD_WAIT;
                        CMD_READ_SEG:    state_next = bad_rd_seg ? S_IDLE : S_RD_WAIT;
                        default:         state_next = S_IDLE;
                    endcase
                end
            S_ADD:
                state_next = S_IDLE;
            S_FR_LANE:
                if (fr_fill != '0) state_next = S_FR_COPY;
                else if (fr_lane_reg == '0) state_next = S_FR_FLUSH;
            S_FR_COPY:
                if (fr_last_j) state_next = (fr_lane_reg == '0) ? S_FR_FLUSH : S_FR_LANE;
            S_FR_FLUSH:
                state_next = S_IDLE;
            S_REV_RD:
                state_next = rev_more ? S_REV_WA : S_SC_INIT;
            S_REV_WA:
                state_next = S_REV_WB;
            S_REV_WB:
                state_next = S_REV_RD;
            S_SC_INIT:
                state_next = (mask_l_reg == '0) ? S_SC_END : S_SC_LOAD;
            S_SC_LOAD:
                state_next = S_SC_RD;
            S_SC_RD:
                state_next = S_SC_PROC;
            S_SC_PROC:
                state_next = sc_last ? S_SC_END : S_SC_RD;
            S_SC_END:
                state_next = S_IDLE;
            S_RD_WAIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        begin_cmd_next   = begin_cmd_reg;
        mask_m_next      = mask_m_reg;
        mask_l_next      = mask_l_reg;
        mask_q_next      = mask_q_reg;
        q_acc_next       = q_acc_reg;
        clr_addr_next    = clr_addr_reg;
        current_row_next = current_row_reg;
        stored_next      = stored_reg;
        segs_next        = segs_reg;
        nonempty_next    = nonempty_reg;
        lane_open_next   = lane_open_reg;
        lane_last_next   = lane_last_reg;
        slot_fill_next   = slot_fill_reg;
        k_next           = k_reg;
        off_next         = off_reg;
        lane_next        = lane_reg;
        fr_lane_next     = fr_lane_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        n_next           = n_reg;
        j_next           = j_reg;
        pend_v_next      = 1'b0;
        pend_addr_next   = pend_addr_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        hold_next        = hold_reg;
        i_next           = i_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        pos_next         = pos_reg;
        s_next           = s_reg;
        start_hold_next  = start_hold_reg;
        rd_kind_next     = rd_kind_reg;
        row_zero_next    = row_zero_reg;

        done           = 1'b0;
        res_status     = STAT_OK;
        res_cell_k     = '0;
        res_row_count  = '0;
        res_row_offset = '0;
        res_seg_start  = '0;
        res_seg_end    = '0;

        cell_we      = pend_v_reg;
        cell_waddr   = pend_addr_reg;
        cell_wdata   = cell_rdata_a;
        cell_raddr_a = '0;
        cell_raddr_b = CIW'(b_reg);
        rc_we        = 1'b0;
        rc_waddr     = clr_addr_reg;
        rc_wdata     = '0;
        rc_raddr     = RCW'(req.row);
        off_we       = 1'b0;
        off_waddr    = RCW'(i_reg);
        off_wdata    = pos_reg;
        off_raddr    = RCW'(req.row);
        seg_we       = 1'b0;
        seg_waddr    = s_reg;
        seg_wdata    = {sc_start, SGW'(i_reg)};
        seg_raddr    = SIW'(req.read_index);

        unique case (state_reg)
            S_CLEAR:
            begin
                rc_we = 1'b1;
                if (clr_addr_reg != RCW'(MAX_SEQUENCE))
                begin
                    clr_addr_next = clr_addr_reg + RCW'(1);
                end
                if (q_acc_reg < KW'(mask_m_reg))
                begin
                    q_acc_next  = q_acc_reg + KW'(LANES);
                    mask_q_next = mask_q_reg + MW'(1);
                end
                done = clr_done && begin_cmd_reg;
            end
            S_IDLE:
            begin
                cell_raddr_a = CIW'(req.read_index);
                if (accept)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_BEGIN:
                        begin
                            begin_cmd_next   = 1'b1;
                            mask_m_next      = mm_clamp;
                            mask_l_next      = ml_clamp;
                            mask_q_next      = '0;
                            q_acc_next       = '0;
                            clr_addr_next    = '0;
                            stored_next      = '0;
                            segs_next        = '0;
                            nonempty_next    = '0;
                            current_row_next = ml_clamp + RW'(1);
                            lane_open_next   = '0;
                            for (int l = 0; l < LANES; l++)
                            begin
                                slot_fill_next[l] = '0;
                            end
                        end
                        CMD_START_ROW:
                        begin
                            done = 1'b1;
                            if (bad_start)
                            begin
                                res_status = STAT_ROW;
                            end
                            else
                            begin
                                current_row_next = RW'(req.row);
                                lane_open_next   = '1;
                                for (int l = 0; l < LANES; l++)
                                begin
                                    slot_fill_next[l] = '0;
                                    lane_last_next[l] = KW'(mask_m_reg) + KW'(1);
                                end
                            end
                        end
                        CMD_ADD_CELL:
                        begin
                            k_next    = KW'(req.lane) * KW'(mask_q_reg)
                                        + KW'(req.stripe_index) + KW'(1);
                            off_next  = (KW'(LANES - 1) - KW'(req.lane)) * KW'(mask_q_reg);
                            lane_next = LIW'(req.lane);
                            if (bad_add)
                            begin
                                done       = 1'b1;
                                res_status = STAT_CELL;
                            end
                        end
                        CMD_FINISH_ROW:
                        begin
                            fr_lane_next = LIW'(LANES - 2);
                            src_next     = PW'(stored_reg) + PW'(mask_q_reg);
                            dst_next     = PW'(stored_reg) + PW'(slot_fill_reg[LANES-1]);
                            n_next       = slot_fill_reg[LANES-1];
                            if (bad_fin_row)
                            begin
                                done       = 1'b1;
                                res_status = STAT_ROW;
                            end
                        end
                        CMD_FINISH_MASK:
                        begin
                            a_next = '0;
                            b_next = (stored_reg == '0) ? '0 : stored_reg - CAW'(1);
                            if (bad_fin_mask)
                            begin
                                done       = 1'b1;
                                res_status = STAT_ROW;
                            end
                        end
                        CMD_READ_CELL:
                        begin
                            rd_kind_next = RK_CELL;
                            if (bad_rd_cell)
                            begin
                                done       = 1'b1;
                                res_status = STAT_INDEX;
                            end
                        end
                        CMD_READ_ROW:
                        begin
                            rd_kind_next  = RK_ROW;
                            row_zero_next = (req.row == '0);
                            if (bad_rd_row)
                            begin
                                done       = 1'b1;
                                res_status = STAT_ROW;
                            end
                        end
                        CMD_READ_SEG:
                        begin
                            rd_kind_next = RK_SEG;
                            if (bad_rd_seg)
                            begin
                                done       = 1'b1;
                                res_status = STAT_INDEX;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                done = 1'b1;
                if (add_bad_k)
                begin
                    res_status = STAT_CELL;
                end
                else if (add_ovf)
                begin
                    res_status = STAT_OVERFLOW;
                end
                else
                begin
                    cell_we                  = 1'b1;
                    cell_waddr               = CIW'(add_pos);
                    cell_wdata               = MW'(k_reg);
                    slot_fill_next[lane_reg] = slot_fill_reg[lane_reg] + MW'(1);
                    lane_last_next[lane_reg] = k_reg;
                end
            end
            S_FR_LANE:
            begin
                j_next = '0;
                if (fr_fill == '0)
                begin
                    src_next = src_reg + PW'(mask_q_reg);
                    if (fr_lane_reg != '0)
                    begin
                        fr_lane_next = fr_lane_reg - LIW'(1);
                    end
                end
            end
            S_FR_COPY:
            begin
                cell_raddr_a   = CIW'(src_reg + PW'(j_reg));
                pend_v_next    = 1'b1;
                pend_addr_next = CIW'(dst_reg + PW'(j_reg));
                if (fr_last_j)
                begin
                    dst_next = dst_reg + PW'(fr_fill);
                    n_next   = n_reg + fr_fill;
                    src_next = src_reg + PW'(mask_q_reg);
                    if (fr_lane_reg != '0)
                    begin
                        fr_lane_next = fr_lane_reg - LIW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + MW'(1);
                end
            end
            S_FR_FLUSH:
            begin
                done           = 1'b1;
                rc_we          = 1'b1;
                rc_waddr       = RCW'(current_row_reg);
                rc_wdata       = n_reg;
                stored_next    = stored_reg + CAW'(n_reg);
                lane_open_next = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    slot_fill_next[l] = '0;
                end
            end
            S_REV_RD:
            begin
                cell_raddr_a = CIW'(a_reg);
            end
            S_REV_WA:
            begin
                cell_we    = 1'b1;
                cell_waddr = CIW'(a_reg);
                cell_wdata = cell_rdata_b;
                hold_next  = cell_rdata_a;
            end
            S_REV_WB:
            begin
                cell_we    = 1'b1;
                cell_waddr = CIW'(b_reg);
                cell_wdata = hold_reg;
                a_next     = a_reg + CAW'(1);
                b_next     = b_reg - CAW'(1);
            end
            S_SC_INIT:
            begin
                seg_we        = 1'b1;
                seg_waddr     = '0;
                seg_wdata     = '1;
                rc_raddr      = RCW'(1);
                i_next        = RW'(1);
                prev_next     = '0;
                pos_next      = '0;
                s_next        = SIW'(1);
                segs_next     = '0;
                nonempty_next = '0;
            end
            S_SC_LOAD:
            begin
                cur_next = rc_rdata;
            end
            S_SC_RD:
            begin
                rc_raddr = RCW'(i_reg + RW'(1));
            end
            S_SC_PROC:
            begin
                off_we    = 1'b1;
                pos_next  = pos_reg + CAW'(cur_reg);
                prev_next = cur_reg;
                cur_next  = sc_nxt;
                if (!sc_last)
                begin
                    i_next = i_reg + RW'(1);
                end
                if (cur_reg != '0)
                begin
                    nonempty_next = nonempty_reg + RW'(1);
                    if (prev_reg == '0)
                    begin
                        segs_next       = segs_reg + SIW'(1);
                        start_hold_next = i_reg;
                    end
                    if (sc_nxt == '0)
                    begin
                        seg_we = 1'b1;
                        s_next = s_reg + SIW'(1);
                    end
                end
            end
            S_SC_END:
            begin
                done             = 1'b1;
                seg_we           = 1'b1;
                seg_wdata        = {SGW'(mask_l_reg + RW'(2)), SGW'(mask_l_reg + RW'(2))};
                current_row_next = '0;
                lane_open_next   = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    slot_fill_next[l] = '0;
                end
            end
            S_RD_WAIT:
            begin
                done = 1'b1;
                case (rd_kind_reg)
                    RK_CELL:
                        res_cell_k = CELLK_W'(cell_rdata_a);
                    RK_ROW:
                    begin
                        res_row_count  = RCOUNT_W'(rc_rdata);
                        res_row_offset = row_zero_reg ? '0 : ROFF_W'(off_rdata);
                    end
                    RK_SEG:
                    begin
                        res_seg_start = SEG_W'($signed(seg_rdata[2*SGW-1:SGW]));
                        res_seg_end   = SEG_W'($signed(seg_rdata[SGW-1:0]));
                    end
                    default:
                        res_cell_k = '0;
                endcase
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            begin_cmd_reg   <= 1'b0;
            mask_m_reg      <= MW'(1);
            mask_l_reg      <= RW'(1);
            mask_q_reg      <= '0;
            q_acc_reg       <= '0;
            clr_addr_reg    <= '0;
            current_row_reg <= RW'(2);
            stored_reg      <= '0;
            segs_reg        <= '0;
            nonempty_reg    <= '0;
            lane_open_reg   <= '0;
            for (int l = 0; l < LANES; l++)
            begin
                slot_fill_reg[l] <= '0;
            end
            pend_v_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            begin_cmd_reg   <= begin_cmd_next;
            mask_m_reg      <= mask_m_next;
            mask_l_reg      <= mask_l_next;
            mask_q_reg      <= mask_q_next;
            q_acc_reg       <= q_acc_next;
            clr_addr_reg    <= clr_addr_next;
            current_row_reg <= current_row_next;
            stored_reg      <= stored_next;
            segs_reg        <= segs_next;
            nonempty_reg    <= nonempty_next;
            lane_open_reg   <= lane_open_next;
            slot_fill_reg   <= slot_fill_next;
            pend_v_reg      <= pend_v_next;
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_last_reg  <= lane_last_next;
        k_reg          <= k_next;
        off_reg        <= off_next;
        lane_reg       <= lane_next;
        fr_lane_reg    <= fr_lane_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        n_reg          <= n_next;
        j_reg          <= j_next;
        pend_addr_reg  <= pend_addr_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        hold_reg       <= hold_next;
        i_reg          <= i_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        s_reg          <= s_next;
        start_hold_reg <= start_hold_next;
        rd_kind_reg    <= rd_kind_next;
        row_zero_reg   <= row_zero_next;
        if (done)
        begin
            rsp_status_reg      <= res_status;
            rsp_cell_k_reg      <= res_cell_k;
            rsp_row_count_reg   <= res_row_count;
            rsp_row_offset_reg  <= res_row_offset;
            rsp_seg_start_reg   <= res_seg_start;
            rsp_seg_end_reg     <= res_seg_end;
            rsp_seg_total_reg   <= SEGTOT_W'(segs_next);
            rsp_rows_marked_reg <= RMARK_W'(nonempty_next);
            rsp_cells_total_reg <= CTOT_W'(stored_next);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.cell_k        = rsp_cell_k_reg;
    assign rsp.row_count     = rsp_row_count_reg;
    assign rsp.row_offset    = rsp_row_offset_reg;
    assign rsp.segment_start = rsp_seg_start_reg;
    assign rsp.segment_end   = rsp_seg_end_reg;
    assign rsp.segment_total = rsp_seg_total_reg;
    assign rsp.rows_marked   = rsp_rows_marked_reg;
    assign rsp.cells_total   = rsp_cells_total_reg;

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the sparse DP mask builder: random and directed command streams checked by a predictor.
module tb_top;
    import sdm_pkg::*;

    localparam int NLANES     = LANES_DEF;
    localparam int CAPACITY   = CELL_CAPACITY_DEF;
    localparam int SEG_SLOTS  = MAX_SEQUENCE_DEF / 2 + 3;
    localparam int ITEM_GOAL  = 1400;
    localparam int CYCLE_CAP  = 2000000;

    typedef struct packed {
        cmd_t                cmd;
        logic [ROW_W-1:0]    row;
        logic [STRIPE_W-1:0] q;
        logic [LANE_W-1:0]   lane;
        logic [RIDX_W-1:0]   idx;
    } mask_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [CELLK_W-1:0]      cell_k;
        logic [RCOUNT_W-1:0]     row_count;
        logic [ROFF_W-1:0]       row_offset;
        logic signed [SEG_W-1:0] seg_start;
        logic signed [SEG_W-1:0] seg_end;
        logic [SEGTOT_W-1:0]     seg_total;
        logic [RMARK_W-1:0]      rows_marked;
        logic [CTOT_W-1:0]       cells_total;
    } mask_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sdm_req_if req_ch ();
    sdm_rsp_if rsp_ch ();

    sparse_dp_mask_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    int unsigned reg_m, reg_l;
    int unsigned mask_m, mask_l, mask_q;
    int unsigned mask_cells[$];
    int unsigned lane_k[NLANES][128];
    int unsigned lane_fill[NLANES];
    int          lane_last[NLANES];
    int unsigned row_cnt[0:MAX_SEQUENCE_DEF];
    int unsigned row_off[0:MAX_SEQUENCE_DEF];
    bit          row_off_set[0:MAX_SEQUENCE_DEF];
    int          seg_lo[0:SEG_SLOTS-1];
    int          seg_hi[0:SEG_SLOTS-1];
    bit          seg_set[0:SEG_SLOTS-1];
    int unsigned open_row, stored, seg_count, busy_rows;

    mask_cmd_t   pending_cmds[$];
    mask_rsp_t   expected_rsps[$];
    mask_cmd_t   shown_cmd;
    int          outstanding = 0;
    int          errors = 0;
    int          pushed = 0;
    int          send_idle = 9;
    int          recv_idle = 86;
    int unsigned cycles = 0;

    function automatic void close_lanes();
        for (int l = 0; l < NLANES; l++)
        begin
            lane_last[l] = -1;
            lane_fill[l] = 0;
        end
    endfunction

    function automatic void open_mask();
        mask_m = reg_m > MAX_MODEL_DEF ? MAX_MODEL_DEF : reg_m;
        mask_l = reg_l > MAX_SEQUENCE_DEF ? MAX_SEQUENCE_DEF : reg_l;
        mask_q = (mask_m + NLANES - 1) / NLANES;
        for (int i = 0; i <= MAX_SEQUENCE_DEF; i++)
            row_cnt[i] = 0;
        mask_cells.delete();
        stored = 0;
        seg_count = 0;
        busy_rows = 0;
        open_row = mask_l + 1;
        close_lanes();
    endfunction

    function automatic void seal_mask();
        int unsigned tmp, pos, s;
        pos = 0;
        s = 1;
        for (int a = 0, b = int'(stored) - 1; a < b; a++, b--)
        begin
            tmp = mask_cells[a];
            mask_cells[a] = mask_cells[b];
            mask_cells[b] = tmp;
        end
        seg_count = 0;
        busy_rows = 0;
        row_off[0] = 0;
        seg_lo[0] = -1;
        seg_hi[0] = -1;
        seg_set[0] = 1'b1;
        for (int unsigned i = 1; i <= mask_l; i++)
        begin
            row_off[i] = pos;
            row_off_set[i] = 1'b1;
            pos += row_cnt[i];
            if (row_cnt[i] != 0)
            begin
                busy_rows++;
                if (row_cnt[i-1] == 0)
                begin
                    seg_count++;
                    seg_lo[s] = int'(i);
                end
                if (i == mask_l || row_cnt[i+1] == 0)
                begin
                    seg_hi[s] = int'(i);
                    seg_set[s] = 1'b1;
                    s++;
                end
            end
        end
        seg_lo[s] = int'(mask_l + 2);
        seg_hi[s] = int'(mask_l + 2);
        seg_set[s] = 1'b1;
        open_row = 0;
        close_lanes();
    endfunction

    function automatic mask_rsp_t step_mask(mask_cmd_t it);
        mask_rsp_t o;
        int unsigned k, pos, n, r, rw, ix;
        o = '0;
        o.status = STAT_OK;
        r = it.lane;
        rw = it.row;
        ix = it.idx;
        case (it.cmd)
            CMD_BEGIN: open_mask();
            CMD_START_ROW:
                if (rw < 1 || rw > mask_l || rw >= open_row)
                    o.status = STAT_ROW;
                else
                begin
                    open_row = rw;
                    for (int l = 0; l < NLANES; l++)
                    begin
                        lane_fill[l] = 0;
                        lane_last[l] = int'(mask_m + 1);
                    end
                end
            CMD_ADD_CELL:
            begin
                k = r * mask_q + it.q + 1;
                if (it.q >= mask_q || lane_last[r] == -1 || int'(k) >= lane_last[r])
                    o.status = STAT_CELL;
                else
                begin
                    pos = stored + (NLANES - 1 - r) * mask_q + lane_fill[r];
                    if (pos >= CAPACITY)
                        o.status = STAT_OVERFLOW;
                    else
                    begin
                        lane_k[r][lane_fill[r]] = k;
                        lane_fill[r]++;
                        lane_last[r] = int'(k);
                    end
                end
            end
            CMD_FINISH_ROW:
                if (lane_last[0] == -1 || open_row < 1 || open_row > mask_l)
                    o.status = STAT_ROW;
                else
                begin
                    n = 0;
                    for (int l = NLANES - 1; l >= 0; l--)
                        for (int j = 0; j < int'(lane_fill[l]); j++)
                        begin
                            mask_cells.push_back(lane_k[l][j]);
                            n++;
                        end
                    row_cnt[open_row] = n;
                    stored += n;
                    close_lanes();
                end
            CMD_FINISH_MASK:
                if (open_row == 0)
                    o.status = STAT_ROW;
                else
                    seal_mask();
            CMD_READ_CELL:
                if (ix >= stored)
                    o.status = STAT_INDEX;
                else
                    o.cell_k = mask_cells[ix];
            CMD_READ_ROW:
                if (rw > mask_l)
                    o.status = STAT_ROW;
                else
                begin
                    o.row_count = row_cnt[rw];
                    o.row_offset = rw == 0 ? 0 : row_off[rw];
                end
            default:
                if (ix > seg_count + 1 || ix >= SEG_SLOTS)
                    o.status = STAT_INDEX;
                else
                begin
                    o.seg_start = seg_lo[ix];
                    o.seg_end = seg_hi[ix];
                end
        endcase
        o.seg_total = seg_count;
        o.rows_marked = busy_rows;
        o.cells_total = stored;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(step_mask(shown_cmd));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    shown_cmd = pending_cmds.pop_front();
                    outstanding++;
                    req_ch.valid <= 1'b1;
                    req_ch.cmd <= shown_cmd.cmd;
                    req_ch.row <= shown_cmd.row;
                    req_ch.stripe_index <= shown_cmd.q;
                    req_ch.lane <= shown_cmd.lane;
                    req_ch.read_index <= shown_cmd.idx;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_result(input mask_rsp_t e);
        if (rsp_ch.status !== e.status)
            $error("status expected %0d got %0d", e.status, rsp_ch.status);
        if (rsp_ch.cell_k !== e.cell_k)
            $error("cell_k expected %0d got %0d", e.cell_k, rsp_ch.cell_k);
        if (rsp_ch.row_count !== e.row_count)
            $error("row_count expected %0d got %0d", e.row_count, rsp_ch.row_count);
        if (rsp_ch.row_offset !== e.row_offset)
            $error("row_offset expected %0d got %0d", e.row_offset, rsp_ch.row_offset);
        if (rsp_ch.segment_start !== e.seg_start)
            $error("segment_start expected %0d got %0d", e.seg_start, rsp_ch.segment_start);
        if (rsp_ch.segment_end !== e.seg_end)
            $error("segment_end expected %0d got %0d", e.seg_end, rsp_ch.segment_end);
        if (rsp_ch.segment_total !== e.seg_total)
            $error("segment_total expected %0d got %0d", e.seg_total, rsp_ch.segment_total);
        if (rsp_ch.rows_marked !== e.rows_marked)
            $error("rows_marked expected %0d got %0d", e.rows_marked, rsp_ch.rows_marked);
        if (rsp_ch.cells_total !== e.cells_total)
            $error("cells_total expected %0d got %0d", e.cells_total, rsp_ch.cells_total);
        if (rsp_ch.status !== e.status || rsp_ch.cell_k !== e.cell_k
            || rsp_ch.row_count !== e.row_count || rsp_ch.row_offset !== e.row_offset
            || rsp_ch.segment_start !== e.seg_start || rsp_ch.segment_end !== e.seg_end
            || rsp_ch.segment_total !== e.seg_total || rsp_ch.rows_marked !== e.rows_marked
            || rsp_ch.cells_total !== e.cells_total)
            errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    check_result(expected_rsps.pop_front());
                    outstanding--;
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(input cmd_t c, input int unsigned rw, input int unsigned q,
                            input int unsigned ln, input int unsigned ix);
        mask_cmd_t it;
        it.cmd = c;
        it.row = rw[ROW_W-1:0];
        it.q = q[STRIPE_W-1:0];
        it.lane = ln[LANE_W-1:0];
        it.idx = ix[RIDX_W-1:0];
        pending_cmds.push_back(it);
        pushed++;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (ri == CFG_MODEL_LENGTH)
            reg_m = val & 32'hFFF;
        else
            reg_l = val & 32'h1FFF;
    endtask

    // keep reads off entries that were never written
    task automatic push_read(input cmd_t c, input int unsigned rw, input int unsigned ix,
                             input int unsigned rows, input int unsigned segs);
        if (c == CMD_READ_ROW && rw >= 1 && rw <= rows && !row_off_set[rw])
            rw = 0;
        if (c == CMD_READ_SEG && ix <= segs + 1 && ix < SEG_SLOTS && !seg_set[ix])
            ix = segs + 2;
        push_cmd(c, rw, $urandom, $urandom, ix);
    endtask

    task automatic push_noise(input int unsigned rows);
        cmd_t c;
        c = cmd_t'($urandom_range(1, 7));
        if (c == CMD_FINISH_MASK && $urandom_range(4) != 0)
            c = CMD_FINISH_ROW;
        if (c == CMD_READ_ROW || c == CMD_READ_SEG)
            push_read(c, $urandom, $urandom, rows, 0);
        else
            push_cmd(c, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic build_mask(input int unsigned m, input int unsigned l);
        int unsigned mc, lc, qc, rw, want, odds, visited, k;
        mc = m > MAX_MODEL_DEF ? MAX_MODEL_DEF : m;
        lc = l > MAX_SEQUENCE_DEF ? MAX_SEQUENCE_DEF : l;
        qc = (mc + NLANES - 1) / NLANES;
        push_cmd(CMD_BEGIN, 0, 0, 0, 0);
        rw = lc;
        visited = 0;
        while (rw >= 1 && visited < 12)
        begin
            push_cmd(CMD_START_ROW, rw, 0, 0, 0);
            want = $urandom_range(0, 10);
            odds = want * 1000 / (qc * NLANES + 1);
            for (int q = int'(qc) - 1; q >= 0; q--)
                for (int r = 0; r < NLANES; r++)
                begin
                    k = r * qc + q + 1;
                    if (k <= mc && ($urandom_range(999) < odds
                        || (q == int'(qc) - 1 && r == NLANES - 1 && $urandom_range(3) == 0)))
                        push_cmd(CMD_ADD_CELL, 0, q, r, 0);
                    if ($urandom_range(999) < 8)
                        push_noise(lc);
                end
            if ($urandom_range(9) == 0)
                push_noise(lc);
            if ($urandom_range(11) != 0)
                push_cmd(CMD_FINISH_ROW, 0, 0, 0, 0);
            visited++;
            if ($urandom_range(2) == 0)
                rw -= 1;
            else
                rw -= $urandom_range(1, lc / 6 + 1);
        end
        push_cmd(CMD_FINISH_MASK, 0, 0, 0, 0);
        drain();
        for (int i = 0; i < 25; i++)
            case ($urandom_range(2))
                0: push_cmd(CMD_READ_CELL, 0, 0, 0,
                            (stored > 0 && $urandom_range(6) != 0)
                            ? $urandom_range(0, stored - 1) : $urandom);
                1: push_read(CMD_READ_ROW,
                             $urandom_range(4) != 0 ? $urandom_range(0, mask_l + 1) : $urandom,
                             0, mask_l, seg_count);
                default: push_read(CMD_READ_SEG, 0,
                                   $urandom_range(4) != 0 ? $urandom_range(0, seg_count + 2)
                                                          : $urandom,
                                   mask_l, seg_count);
            endcase
        drain();
    endtask

    initial
    begin
        int unsigned m, l, n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_BEGIN;
        req_ch.row = '0;
        req_ch.stripe_index = '0;
        req_ch.lane = '0;
        req_ch.read_index = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i <= MAX_SEQUENCE_DEF; i++)
            row_off_set[i] = 1'b0;
        for (int i = 0; i < SEG_SLOTS; i++)
            seg_set[i] = 1'b0;
        reg_m = 1;
        reg_l = 1;
        open_mask();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_MODEL_LENGTH, 37);
        write_reg(CFG_SEQUENCE_LENGTH, 5);
        push_cmd(CMD_BEGIN, 0, 0, 0, 0);
        push_cmd(CMD_FINISH_ROW, 0, 0, 0, 0);
        push_cmd(CMD_READ_ROW, 6, 0, 0, 0);
        push_cmd(CMD_READ_ROW, 0, 0, 0, 0);
        push_cmd(CMD_READ_CELL, 0, 0, 0, 0);
        push_cmd(CMD_READ_SEG, 0, 0, 0, 2);
        push_cmd(CMD_START_ROW, 0, 0, 0, 0);
        push_cmd(CMD_START_ROW, 6, 0, 0, 0);
        push_cmd(CMD_START_ROW, 5, 0, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 3, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 2, 15, 0);
        push_cmd(CMD_ADD_CELL, 0, 0, 12, 0);
        push_cmd(CMD_ADD_CELL, 0, 0, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 0, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 1, 1, 0);
        push_cmd(CMD_START_ROW, 5, 0, 0, 0);
        push_cmd(CMD_START_ROW, 3, 0, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 1, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 0, 0, 0);
        push_cmd(CMD_FINISH_ROW, 0, 0, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 0, 0, 0);
        push_cmd(CMD_START_ROW, 2, 0, 0, 0);
        push_cmd(CMD_ADD_CELL, 0, 2, 11, 0);
        push_cmd(CMD_FINISH_ROW, 0, 0, 0, 0);
        push_cmd(CMD_START_ROW, 1, 0, 0, 0);
        push_cmd(CMD_FINISH_MASK, 0, 0, 0, 0);
        push_cmd(CMD_FINISH_MASK, 0, 0, 0, 0);
        push_cmd(CMD_START_ROW, 1, 0, 0, 0);
        drain();

        n = 0;
        while (pushed < ITEM_GOAL)
        begin
            case (pushed * 3 / ITEM_GOAL)
                0:
                begin
                    send_idle = 9;
                    recv_idle = 86;
                end
                1:
                begin
                    send_idle = 86;
                    recv_idle = 9;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (n)
                0:
                begin
                    m = 2048;
                    l = 4096;
                end
                1:
                begin
                    m = 1;
                    l = 1;
                end
                2:
                begin
                    m = 4095;
                    l = 8191;
                end
                3:
                begin
                    m = 16;
                    l = 2;
                end
                default:
                begin
                    m = $urandom_range(1, 120);
                    l = $urandom_range(1, 40);
                end
            endcase
            write_reg(CFG_MODEL_LENGTH, m);
            write_reg(CFG_SEQUENCE_LENGTH, l);
            build_mask(m, l);
            n++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
